// ===== design/afb_pkg.sv =====
// ----------------------------------------------------------------------------
// afb_pkg
// Shared constants, codes and helpers for the alpha blending framebuffer.
// ----------------------------------------------------------------------------
package afb_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned FRAME_W    = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [FRAME_W-1:0] FRAME_RST    = 9'd256;
  localparam logic [7:0]         ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0]         ALPHA_FULL   = 8'd255;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  // Exact s/255 for s up to 255*255, where the quotient fits a byte.
  function automatic logic [7:0] div255(input logic [16:0] s);
    logic [16:0] t;
    t = s + 17'd1 + (s >> 8);
    return t[15:8];
  endfunction

endpackage

// ===== design/afb_ifs.sv =====
// ----------------------------------------------------------------------------
// afb channel interfaces
// Valid/ready channels for pixel items, results and register writes.
// ----------------------------------------------------------------------------
interface afb_item_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [afb_pkg::COORD_W-1:0]  x_coord;
  logic [afb_pkg::COORD_W-1:0]  y_coord;
  logic [afb_pkg::PIXEL_W-1:0]  pixel_value;

  modport source (output valid, op, x_coord, y_coord, pixel_value, input ready);
  modport sink   (input valid, op, x_coord, y_coord, pixel_value, output ready);
endinterface

interface afb_result_if;
  logic                         valid;
  logic                         ready;
  logic [afb_pkg::PIXEL_W-1:0]  read_data;
  logic                         in_range;

  modport source (output valid, read_data, in_range, input ready);
  modport sink   (input valid, read_data, in_range, output ready);
endinterface

interface afb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [afb_pkg::CFG_IDX_W-1:0]  index;
  logic [afb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/afb_blend.sv =====
// ----------------------------------------------------------------------------
// afb_blend
// Source-over mix of three color channels; products registered, then /255.
// ----------------------------------------------------------------------------
module afb_blend (
  input  logic        clk_i,
  input  logic [31:0] src_i,
  input  logic [31:0] dst_i,
  output logic [31:0] blend_o
);
  import afb_pkg::*;

  logic [7:0]  alpha;
  logic [7:0]  alpha_inv;
  logic [15:0] fg_prod_q [3];
  logic [15:0] bg_prod_q [3];
  logic [7:0]  chan      [3];

  assign alpha     = src_i[7:0];
  assign alpha_inv = ALPHA_FULL - alpha;

  // channel 0 is red (bits 31:24), 1 green, 2 blue
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      fg_prod_q[c] <= 16'(src_i[31-8*c -: 8]) * 16'(alpha);
      bg_prod_q[c] <= 16'(dst_i[31-8*c -: 8]) * 16'(alpha_inv);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan[c] = div255(17'(fg_prod_q[c]) + 17'(bg_prod_q[c]));
    end
  end

  assign blend_o = {chan[0], chan[1], chan[2], ALPHA_OPAQUE};

endmodule

// ===== design/alpha_blend_framebuffer.sv =====
// ----------------------------------------------------------------------------
// alpha_blend_framebuffer
// RGBA8888 framebuffer with overwrite or source-over alpha blend writes.
// ----------------------------------------------------------------------------
// Channels: item_i carries op, x_coord, y_coord and pixel_value; result_o
// returns read_data and in_range, one beat per item; cfg_i writes blend_mode
// (index 0), frame_width (1) and frame_height (2), always ready.
// Sequence: an accepted item registers its address, then steps through
// read, multiply and write-back around the single store; its result beat
// is loaded into the output register as it leaves write-back.
// Items are handled one at a time, so a write lands before the next read.
// Reset: a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT entries,
// one per cycle; item_i.ready stays low meanwhile. Registers reset to
// blend mode, 256 x 256.
// Stall: a finished result waits in the output register; the next item is
// still accepted and processed, and holds in write-back until the output
// register frees up.
// Out-of-frame items leave the store alone and return zero with in_range 0.
// ----------------------------------------------------------------------------
module alpha_blend_framebuffer #(
  parameter int unsigned MAX_WIDTH  = afb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = afb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  afb_item_if.sink            item_i,
  afb_result_if.source        result_o,
  afb_cfg_if.sink             cfg_i
);
  import afb_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [FRAME_W-1:0] WLIM = FRAME_W'((MAX_WIDTH  > 511) ? 511 : MAX_WIDTH);
  localparam logic [FRAME_W-1:0] HLIM = FRAME_W'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);
  localparam logic [AW-1:0]      CLR_LAST = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_MUL   = 5'b01000,
    S_WB    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic               blend_mode_q;
  logic [FRAME_W-1:0] frame_width_q;
  logic [FRAME_W-1:0] frame_height_q;

  logic [AW-1:0]      clr_q, clr_d;

  logic [AW-1:0]      addr_q;
  logic               op_q;
  logic               range_q;
  logic [PIXEL_W-1:0] src_q;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;

  logic               out_valid_q, out_valid_d;
  logic [PIXEL_W-1:0] out_data_q;
  logic               out_range_q;

  logic [FRAME_W-1:0] w_eff;
  logic [FRAME_W-1:0] h_eff;
  logic               hit;
  logic [16:0]        lin_addr;
  logic               item_fire;
  logic               out_free;
  logic               load_out;
  logic [PIXEL_W-1:0] blend_px;
  logic [PIXEL_W-1:0] result;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q   <= 1'b1;
      frame_width_q  <= FRAME_RST;
      frame_height_q <= FRAME_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BLEND_MODE:   blend_mode_q   <= cfg_i.data[0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Bounds test and address
  // --------------------------------------------------------------------------
  assign w_eff    = (frame_width_q  > WLIM) ? WLIM : frame_width_q;
  assign h_eff    = (frame_height_q > HLIM) ? HLIM : frame_height_q;
  assign hit      = (FRAME_W'(item_i.x_coord) < w_eff) && (FRAME_W'(item_i.y_coord) < h_eff);
  assign lin_addr = 17'(item_i.y_coord) * 17'(w_eff) + 17'(item_i.x_coord);

  assign item_i.ready = (state_q == S_IDLE);
  assign item_fire    = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      addr_q  <= AW'(lin_addr);
      op_q    <= item_i.op;
      range_q <= hit;
      src_q   <= item_i.pixel_value;
    end
  end

  // --------------------------------------------------------------------------
  // Frame store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  afb_blend u_blend (
    .clk_i   (clk_i),
    .src_i   (src_q),
    .dst_i   (rdata_q),
    .blend_o (blend_px)
  );

  always_comb begin
    if (!range_q) begin
      result = '0;
    end else if (op_q == OP_READ) begin
      result = rdata_q;
    end else if (blend_mode_q) begin
      result = blend_px;
    end else begin
      result = src_q;
    end
  end

  assign out_free = !out_valid_q || result_o.ready;
  assign load_out = (state_q == S_WB) && out_free;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = result;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (load_out && range_q && (op_q == OP_WRITE)) begin
      mem_we = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_fire) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_MUL;
      S_MUL:   state_d = S_WB;
      S_WB: begin
        // hold until the output register can take the result
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q  <= result;
      out_range_q <= range_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.read_data = out_data_q;
  assign result_o.in_range  = out_range_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_WB) || (state_q == S_CLEAR)))
    else $error("store written outside clear or write-back");

  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WB))
    else $error("result beat appeared without a write-back");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_range_q) |-> (out_data_q == '0))
    else $error("rejected item returned nonzero data");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> ((state_q == S_CLEAR) || (state_q == S_IDLE)))
    else $error("left clearing pass into item processing");

endmodule
